// ===== rtl/sgm_pkg.sv =====
// sgm_pkg: shared constants, queue entry type and back-end state type
// for the sobel gradient magnitude block; no dependencies
`default_nettype none

package sgm_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MIN_WIDTH    = 3;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W      = 12;
    localparam int THR_W        = 11;
    localparam int PIX_W        = 8;
    localparam int SUM_W        = PIX_W + 2;
    localparam int GRAD_W       = 11;
    localparam int MAG_W        = 11;
    localparam int COL_W        = 11;
    localparam int SQ_W         = 2 * GRAD_W - 2;
    localparam int ENERGY_W     = SQ_W + 1;
    localparam int RAD_W        = 2 * MAG_W;
    localparam int REM_W        = MAG_W + 2;
    localparam int STEP_W       = $clog2(MAG_W);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET   = WIDTH_W'(640);
    localparam logic [THR_W-1:0]   MAG_THRESHOLD_RESET = '0;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH   = 1'b0;
    localparam logic REG_MAG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [COL_W-1:0]         centre_col;
        logic                     end_of_row;
    } sgm_entry_t;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_SQUARE,
        BACK_SUM,
        BACK_ROOT,
        BACK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/sgm_front.sv =====
// sgm_front: pixel intake, column and row tracking, line stores, 3x3 window
// and sobel gradients; pushes interior results into the queue; uses sgm_pkg
`default_nettype none

module sgm_front
    import sgm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [WIDTH_W-1:0] image_width,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [PIX_W-1:0]   pixel,
    input  wire logic               start_of_frame,
    input  wire logic               q_full,
    output logic                    q_push,
    output sgm_entry_t              q_entry
);

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    logic [ADDR_W-1:0] col_count_reg, col_count_next;
    logic [1:0]        rows_reg, rows_next;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic [ADDR_W-1:0] s1_col_reg;
    logic              s1_emit_reg;
    logic              s1_eor_reg;
    logic [PIX_W-1:0]  up_rd_reg;
    logic [PIX_W-1:0]  mid_rd_reg;

    logic [PIX_W-1:0] win_c1_reg [3];
    logic [PIX_W-1:0] win_c2_reg [3];

    logic [WIDTH_W-1:0] w_eff;
    logic [ADDR_W-1:0]  base_col;
    logic [ADDR_W-1:0]  col;
    logic               wrap;
    logic               emit;
    logic               eor;
    logic               accept;
    logic               advance;
    logic               fwd;

    logic [SUM_W-1:0]   gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [GRAD_W:0] gx_wide, gy_wide;

    always_comb
    begin
        if (image_width < WIDTH_W'(MIN_WIDTH))
            w_eff = WIDTH_W'(MIN_WIDTH);
        else if (image_width > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = image_width;
    end

    // column of the incoming pixel, wrapping if the width shrank mid-row
    always_comb
    begin
        base_col = start_of_frame ? '0 : col_count_reg;
        if (WIDTH_W'(base_col) >= w_eff)
            col = '0;
        else
            col = base_col;
        wrap = (WIDTH_W'(col) + 1'b1) >= w_eff;
        emit = ((start_of_frame ? 2'd0 : rows_reg) >= 2'd2) && (col >= ADDR_W'(2));
        eor  = (WIDTH_W'(col) == (w_eff - 1'b1));
    end

    assign advance  = s1_valid_reg && (!s1_emit_reg || !q_full);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // same column as the pixel leaving stage one: its write-back is not in memory yet
    assign fwd      = s1_valid_reg && (col == s1_col_reg);

    always_comb
    begin
        col_count_next = col_count_reg;
        rows_next      = rows_reg;
        if (accept)
        begin
            if (start_of_frame)
                rows_next = 2'd0;
            if (wrap)
            begin
                col_count_next = '0;
                if ((start_of_frame ? 2'd0 : rows_reg) < 2'd2)
                    rows_next = (start_of_frame ? 2'd0 : rows_reg) + 2'd1;
            end
            else
            begin
                col_count_next = col + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            rows_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                win_c1_reg[r] <= '0;
                win_c2_reg[r] <= '0;
            end
        end
        else
        begin
            col_count_reg <= col_count_next;
            rows_reg      <= rows_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
            begin
                win_c1_reg[0] <= win_c2_reg[0];
                win_c1_reg[1] <= win_c2_reg[1];
                win_c1_reg[2] <= win_c2_reg[2];
                win_c2_reg[0] <= up_rd_reg;
                win_c2_reg[1] <= mid_rd_reg;
                win_c2_reg[2] <= s1_pixel_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col;
            s1_emit_reg  <= emit;
            s1_eor_reg   <= eor;
        end
    end

    // line stores: read at intake, written back when the pixel leaves stage one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (fwd)
            begin
                up_rd_reg  <= mid_rd_reg;
                mid_rd_reg <= s1_pixel_reg;
            end
            else
            begin
                up_rd_reg  <= upper_mem[col];
                mid_rd_reg <= middle_mem[col];
            end
        end
        if (advance)
        begin
            upper_mem[s1_col_reg]  <= mid_rd_reg;
            middle_mem[s1_col_reg] <= s1_pixel_reg;
        end
    end

    // window after the shift: left column is win_c1, centre is win_c2,
    // right column is the fresh line-store reads and the pixel
    always_comb
    begin
        gx_pos = SUM_W'(up_rd_reg) + {1'b0, mid_rd_reg, 1'b0} + SUM_W'(s1_pixel_reg);
        gx_neg = SUM_W'(win_c1_reg[0]) + {1'b0, win_c1_reg[1], 1'b0} + SUM_W'(win_c1_reg[2]);
        gy_pos = SUM_W'(win_c1_reg[2]) + {1'b0, win_c2_reg[2], 1'b0} + SUM_W'(s1_pixel_reg);
        gy_neg = SUM_W'(win_c1_reg[0]) + {1'b0, win_c2_reg[0], 1'b0} + SUM_W'(up_rd_reg);
        gx_wide = $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
        gy_wide = $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});
    end

    assign q_push             = advance && s1_emit_reg;
    assign q_entry.grad_x     = gx_wide[GRAD_W-1:0];
    assign q_entry.grad_y     = gy_wide[GRAD_W-1:0];
    assign q_entry.centre_col = COL_W'(s1_col_reg - 1'b1);
    assign q_entry.end_of_row = s1_eor_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("stage one lost a pixel while stalled");

endmodule

`default_nettype wire

// ===== rtl/sgm_queue.sv =====
// sgm_queue: small fifo of gradient entries between front and back end
// uses sgm_pkg for the entry type and depth
`default_nettype none

module sgm_queue
    import sgm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  sgm_entry_t      push_data,
    output logic            full,
    input  wire logic       pop,
    output sgm_entry_t      pop_data,
    output logic            empty
);

    sgm_entry_t entry_mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_mem[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/sgm_back.sv =====
// sgm_back: squares the gradients, bit-serial integer square root,
// threshold and output register; uses sgm_pkg
`default_nettype none

module sgm_back
    import sgm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [THR_W-1:0]         mag_threshold,
    input  wire logic                     q_empty,
    input  sgm_entry_t                    q_entry,
    output logic                          q_pop,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [GRAD_W-1:0]      grad_x,
    output logic signed [GRAD_W-1:0]      grad_y,
    output logic [MAG_W-1:0]              magnitude,
    output logic [COL_W-1:0]              centre_col,
    output logic                          end_of_row
);

    back_state_t state_reg, state_next;

    sgm_entry_t        cur_reg, cur_next;
    logic [SQ_W-1:0]   sqx_reg, sqx_next;
    logic [SQ_W-1:0]   sqy_reg, sqy_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              load_out;

    logic signed [2*GRAD_W-1:0] prod_x, prod_y;
    logic [ENERGY_W-1:0]        energy;
    logic [REM_W-1:0]           rem_sh, trial;

    assign prod_x = cur_reg.grad_x * cur_reg.grad_x;
    assign prod_y = cur_reg.grad_y * cur_reg.grad_y;
    assign energy = ENERGY_W'(sqx_reg) + ENERGY_W'(sqy_reg);
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        q_pop          = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_entry;
                    state_next = BACK_SQUARE;
                end
            end
            BACK_SQUARE:
            begin
                sqx_next   = prod_x[SQ_W-1:0];
                sqy_next   = prod_y[SQ_W-1:0];
                state_next = BACK_SUM;
            end
            BACK_SUM:
            begin
                rad_next   = RAD_W'(energy);
                rem_next   = '0;
                root_next  = '0;
                step_next  = STEP_W'(MAG_W - 1);
                state_next = BACK_ROOT;
            end
            BACK_ROOT:
            begin
                // one root bit per cycle, two radicand bits shifted in
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[MAG_W-2:0], 1'b0};
                end
                if (step_reg == '0)
                    state_next = BACK_DONE;
                else
                    step_next = step_reg - 1'b1;
            end
            BACK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            grad_x     <= cur_reg.grad_x;
            grad_y     <= cur_reg.grad_y;
            magnitude  <= (root_reg < mag_threshold) ? '0 : root_reg;
            centre_col <= cur_reg.centre_col;
            end_of_row <= cur_reg.end_of_row;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == BACK_DONE))
        else $error("result shown before the root finished");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BACK_ROOT |-> step_reg <= STEP_W'(MAG_W - 1))
        else $error("root step counter out of range");

endmodule

`default_nettype wire

// ===== rtl/sobel_gradient_magnitude.sv =====
// sobel_gradient_magnitude: 3x3 sobel gradient and magnitude over a pixel stream
// front end takes one pixel per cycle into a 4-deep queue unless a result meets it full;
// back end takes one interior result at a time (square, sum, 11 root bits, output),
// which sets the sustained rate; border pixels give no result
// asynchronous active-low reset clears counters, window, queue and state; no clearing pass
// depends on sgm_pkg, sgm_front, sgm_queue, sgm_back
`default_nettype none

module sobel_gradient_magnitude
    import sgm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [PIX_W-1:0]        pixel,
    input  wire logic                    start_of_frame,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [GRAD_W-1:0]     grad_x,
    output logic signed [GRAD_W-1:0]     grad_y,
    output logic [MAG_W-1:0]             magnitude,
    output logic [COL_W-1:0]             centre_col,
    output logic                         end_of_row
);

    logic [WIDTH_W-1:0] image_width_reg;
    logic [THR_W-1:0]   mag_threshold_reg;
    logic               cfg_write;

    logic       q_push, q_full, q_pop, q_empty;
    sgm_entry_t q_in, q_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= IMAGE_WIDTH_RESET;
            mag_threshold_reg <= MAG_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[WIDTH_W-1:0];
                REG_MAG_THRESHOLD: mag_threshold_reg <= pwdata[THR_W-1:0];
                default:           image_width_reg   <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(image_width_reg);
            REG_MAG_THRESHOLD: prdata = APB_DATA_W'(mag_threshold_reg);
            default:           prdata = '0;
        endcase
    end

    sgm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .image_width    (image_width_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_in)
    );

    sgm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    sgm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mag_threshold (mag_threshold_reg),
        .q_empty       (q_empty),
        .q_entry       (q_out),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .grad_x        (grad_x),
        .grad_y        (grad_y),
        .magnitude     (magnitude),
        .centre_col    (centre_col),
        .end_of_row    (end_of_row)
    );

endmodule

`default_nettype wire
